>>> hw/rtl/iretf_pkg.sv
// Package with shared widths, register indexes and reset values for the IR edge timing filter.
`default_nettype none

package iretf_pkg;

  localparam int SECONDS_BITS   = 32;
  localparam int MICROS_BITS    = 20;
  localparam int TIMEOUT_BITS   = 5;
  localparam int LIMIT_BITS     = 24;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 8;

  // Product of a seconds difference below 32 and one million fits in 25 bits.
  localparam int PROD_BITS = 25;
  localparam logic [PROD_BITS-1:0] US_PER_SECOND = PROD_BITS'(1000000);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_INITIAL_POLARITY  = CFG_INDEX_BITS'(0),
    CFG_PULSE_MERGE_LIMIT = CFG_INDEX_BITS'(1),
    CFG_LONG_SPACE_LIMIT  = CFG_INDEX_BITS'(2),
    CFG_TIMEOUT_SECONDS   = CFG_INDEX_BITS'(3)
  } cfg_index_t;

  localparam logic                    RST_INITIAL_POLARITY  = 1'b1;
  localparam logic [LIMIT_BITS-1:0]   RST_PULSE_MERGE_LIMIT = LIMIT_BITS'(250);
  localparam logic [LIMIT_BITS-1:0]   RST_LONG_SPACE_LIMIT  = LIMIT_BITS'(20000);
  localparam logic [TIMEOUT_BITS-1:0] RST_TIMEOUT_SECONDS   = TIMEOUT_BITS'(15);

endpackage

`default_nettype wire

>>> hw/rtl/iretf_if.sv
// Handshake interfaces for receiver edge items and pulse/space result items.
`default_nettype none

interface iretf_edge_if
  import iretf_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    line_level;
  logic [SECONDS_BITS-1:0] stamp_seconds;
  logic [MICROS_BITS-1:0]  stamp_micros;

  modport source (output valid, line_level, stamp_seconds, stamp_micros, input ready);
  modport sink   (input valid, line_level, stamp_seconds, stamp_micros, output ready);
endinterface

interface iretf_word_if #(
  parameter int DURATION_BITS = 24
) ();
  logic                     valid;
  logic                     ready;
  logic                     is_pulse;
  logic [DURATION_BITS-1:0] duration_us;
  logic                     last_word;

  modport source (output valid, is_pulse, duration_us, last_word, input ready);
  modport sink   (input valid, is_pulse, duration_us, last_word, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ir_edge_timing_filter_core.sv
// IR receiver edge timing filter: edge durations, pulse/space tagging and long-space merging.
//
//  channel  | direction | handshake    | payload
//  ---------+-----------+--------------+---------------------------------------------
//  edges    | in        | valid/ready  | line_level, stamp_seconds, stamp_micros
//  words    | out       | valid/ready  | is_pulse, duration_us, last_word
//  cfg      | in        | cfg_we only  | cfg_index, cfg_data (no read-back)
//
// An edge has its duration registered at the clock edge that accepts it; once the result
// buffer is free, it is tagged, filtered and loaded into the result buffer as zero to three
// words, which leave from the buffer registers. The buffer sends one word per cycle while
// words is ready. Edges that leave at most one word are accepted every cycle while words is
// ready; while a two- or three-word group drains, one more edge waits in the duration
// register and edges stalls. Reset is synchronous; a stall on words backs up into edges.
`default_nettype none

module ir_edge_timing_filter_core
  import iretf_pkg::*;
#(
  parameter int DURATION_BITS = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  iretf_edge_if.sink                     edges,
  iretf_word_if.source                   words,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int DB = DURATION_BITS;
  localparam logic [31:0] DUR_MAX32 = (32'd1 << DB) - 32'd1;
  localparam logic [DB-1:0] DUR_MAX = {DB{1'b1}};
  localparam int SUM_BITS = PROD_BITS + 3;

  function automatic logic [DB-1:0] sat_add(input logic [DB-1:0] a, input logic [DB-1:0] b);
    logic [DB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DB] ? DUR_MAX : s[DB-1:0];
  endfunction

  // Configuration registers; a polarity write loads the polarity state directly.
  logic [LIMIT_BITS-1:0]   pulse_merge_limit;
  logic [LIMIT_BITS-1:0]   long_space_limit;
  logic [TIMEOUT_BITS-1:0] timeout_seconds;

  // Filter state.
  logic [SECONDS_BITS-1:0] prev_seconds;
  logic [MICROS_BITS-1:0]  prev_micros;
  logic                    polarity;
  logic                    space_held;
  logic [DB-1:0]           held_space;
  logic [DB-1:0]           merged_pulse;

  // Duration stage register.
  logic          a_valid;
  logic          a_level;
  logic          a_timeout;
  logic [DB-1:0] a_dur;

  // Result buffer.
  logic          buf_pulse [0:2];
  logic [DB-1:0] buf_dur   [0:2];
  logic [1:0]    ptr;
  logic [1:0]    rem;

  logic in_fire, out_fire, buf_free, b_take;

  assign out_fire = words.valid && words.ready;
  assign buf_free = (rem == 2'd0) || (rem == 2'd1 && words.ready);
  assign b_take   = a_valid && buf_free;
  assign edges.ready = !a_valid || b_take;
  assign in_fire  = edges.valid && edges.ready;

  // ---------------- duration from the timestamps ----------------
  logic                        backward;
  logic [SECONDS_BITS-1:0]     dsec;
  logic                        timeout;
  logic [PROD_BITS-1:0]        prod;
  logic signed [SUM_BITS-1:0]  diff;
  logic [31:0]                 diff32;
  logic [DB-1:0]               dur_in;

  always_comb begin
    backward = (edges.stamp_seconds < prev_seconds) ||
               (edges.stamp_seconds == prev_seconds && edges.stamp_micros < prev_micros);
    dsec    = edges.stamp_seconds - prev_seconds;
    timeout = !backward && (dsec > {{(SECONDS_BITS-TIMEOUT_BITS){1'b0}}, timeout_seconds});
    prod    = PROD_BITS'(dsec[TIMEOUT_BITS-1:0]) * US_PER_SECOND;
    diff    = $signed({3'b000, prod}) + $signed(SUM_BITS'(edges.stamp_micros))
              - $signed(SUM_BITS'(prev_micros));
    diff32  = {{(32-SUM_BITS){1'b0}}, diff};
    if (backward || timeout) begin
      dur_in = DUR_MAX;
    end else if (diff < 0) begin
      dur_in = '0;
    end else if (diff32 > DUR_MAX32) begin
      dur_in = DUR_MAX;
    end else begin
      dur_in = diff32[DB-1:0];
    end
  end

  // ---------------- tagging and merge filter ----------------
  logic          pol_eff;
  logic          pulse;
  logic [DB-1:0] merged_sum;
  logic [DB-1:0] held_sum;
  logic          merged_over;
  logic          dur_long;
  logic          space_held_next;
  logic [DB-1:0] held_space_next;
  logic [DB-1:0] merged_pulse_next;
  logic [1:0]    n_words;
  logic          w_pulse [0:2];
  logic [DB-1:0] w_dur   [0:2];

  always_comb begin
    pol_eff     = (a_timeout && a_level == polarity) ? !polarity : polarity;
    pulse       = (a_level == pol_eff);
    merged_sum  = sat_add(merged_pulse, a_dur);
    held_sum    = sat_add(sat_add(held_space, merged_pulse), a_dur);
    merged_over = {{(32-DB){1'b0}}, merged_sum} > {8'h00, pulse_merge_limit};
    dur_long    = {{(32-DB){1'b0}}, a_dur} > {8'h00, long_space_limit};

    space_held_next   = space_held;
    held_space_next   = held_space;
    merged_pulse_next = merged_pulse;
    n_words = 2'd0;
    for (int i = 0; i < 3; i++) begin
      w_pulse[i] = 1'b0;
      w_dur[i]   = a_dur;
    end

    if (space_held && pulse) begin
      merged_pulse_next = merged_sum;
      if (merged_over) begin
        n_words = 2'd2;
        w_pulse[0] = 1'b0; w_dur[0] = held_space;
        w_pulse[1] = 1'b1; w_dur[1] = merged_sum;
        space_held_next   = 1'b0;
        merged_pulse_next = '0;
      end
    end else if (pulse) begin
      n_words = 2'd1;
      w_pulse[0] = 1'b1; w_dur[0] = a_dur;
    end else if (!space_held) begin
      if (dur_long) begin
        held_space_next = a_dur;
        space_held_next = 1'b1;
      end else begin
        n_words = 2'd1;
        w_pulse[0] = 1'b0; w_dur[0] = a_dur;
      end
    end else if (dur_long) begin
      // Another long space while holding: fold everything into the held space.
      held_space_next   = held_sum;
      merged_pulse_next = '0;
    end else begin
      n_words = 2'd3;
      w_pulse[0] = 1'b0; w_dur[0] = held_space;
      w_pulse[1] = 1'b1; w_dur[1] = merged_pulse;
      w_pulse[2] = 1'b0; w_dur[2] = a_dur;
      space_held_next   = 1'b0;
      merged_pulse_next = '0;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_merge_limit <= RST_PULSE_MERGE_LIMIT;
      long_space_limit  <= RST_LONG_SPACE_LIMIT;
      timeout_seconds   <= RST_TIMEOUT_SECONDS;
      polarity          <= RST_INITIAL_POLARITY;
      prev_seconds      <= '0;
      prev_micros       <= '0;
      space_held        <= 1'b0;
      held_space        <= '0;
      merged_pulse      <= '0;
      a_valid           <= 1'b0;
      ptr               <= 2'd0;
      rem               <= 2'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INITIAL_POLARITY:  polarity          <= cfg_data[0];
          CFG_PULSE_MERGE_LIMIT: pulse_merge_limit <= cfg_data[LIMIT_BITS-1:0];
          CFG_LONG_SPACE_LIMIT:  long_space_limit  <= cfg_data[LIMIT_BITS-1:0];
          CFG_TIMEOUT_SECONDS:   timeout_seconds   <= cfg_data[TIMEOUT_BITS-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        prev_seconds <= edges.stamp_seconds;
        prev_micros  <= edges.stamp_micros;
        a_valid      <= 1'b1;
      end else if (b_take) begin
        a_valid <= 1'b0;
      end

      if (b_take) begin
        polarity     <= pol_eff;
        space_held   <= space_held_next;
        held_space   <= held_space_next;
        merged_pulse <= merged_pulse_next;
        ptr          <= 2'd0;
        rem          <= n_words;
      end else if (out_fire) begin
        ptr <= ptr + 2'd1;
        rem <= rem - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_level   <= edges.line_level;
      a_timeout <= timeout;
      a_dur     <= dur_in;
    end
    if (b_take) begin
      for (int i = 0; i < 3; i++) begin
        buf_pulse[i] <= w_pulse[i];
        buf_dur[i]   <= w_dur[i];
      end
    end
  end

  assign words.valid       = (rem != 2'd0);
  assign words.is_pulse    = buf_pulse[ptr];
  assign words.duration_us = buf_dur[ptr];
  assign words.last_word   = (rem == 2'd1);

  // ---------------- assertions ----------------
  a_merge_only_when_held: assert property (@(posedge clk) disable iff (rst)
    !space_held |-> merged_pulse == '0)
    else $error("merged pulse nonzero without a held space");

  a_words_continue: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !words.last_word) |=> words.valid)
    else $error("result words of one edge were interrupted");

  a_last_ends_group: assert property (@(posedge clk) disable iff (rst)
    (out_fire && words.last_word) |=> (rem == 2'd0 || ptr == 2'd0))
    else $error("buffer not empty or reloaded after last word");

  a_stamp_tracked: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> prev_micros == $past(edges.stamp_micros))
    else $error("previous timestamp not updated on accepted edge");

endmodule

`default_nettype wire

>>> verif/tb_ir_edge_timing_filter_core.sv
// Self-checking testbench for the IR edge timing filter core: directed edges, then random edge trains.
`timescale 1ns / 1ps

module tb_ir_edge_timing_filter_core;
  import iretf_pkg::*;

  localparam int DUR_BITS = 24;
  localparam logic [DUR_BITS-1:0] DUR_MAX = '1;
  localparam int N_DIRECTED = 24;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam longint RUN_LIMIT_NS = 20_000_000;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NO_SUCH_REG = CFG_INDEX_BITS'(9);

  typedef struct packed {
    logic                is_pulse;
    logic [DUR_BITS-1:0] duration_us;
    logic                last_word;
  } ir_word_t;

  // One directed edge; typed rows carry the single word, if any, the block must send for it.
  typedef struct packed {
    logic                    lvl;
    logic [SECONDS_BITS-1:0] sec;
    logic [MICROS_BITS-1:0]  us;
    logic                    typed;
    logic                    typed_has_word;
    logic                    typed_pulse;
    logic [DUR_BITS-1:0]     typed_dur;
  } edge_row_t;

  localparam edge_row_t DIRECTED [N_DIRECTED] = '{
    '{1'b0, 32'd0,          20'd500,     1'b1, 1'b1, 1'b0, 24'd500},
    '{1'b1, 32'd0,          20'd1060,    1'b1, 1'b1, 1'b1, 24'd560},
    '{1'b0, 32'd0,          20'd1000,    1'b1, 1'b0, 1'b0, 24'd0},
    '{1'b1, 32'd0,          20'd1100,    1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b0, 32'd0,          20'd1300,    1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b1, 32'd0,          20'd999999,  1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b0, 32'd1,          20'hFFFFF,   1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b1, 32'd2,          20'd0,       1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b1, 32'd18,         20'd0,       1'b1, 1'b0, 1'b0, 24'd0},
    '{1'b0, 32'd18,         20'd300,     1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b1, 32'd40,         20'd5,       1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b0, 32'd40,         20'd255,     1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b0, 32'd40,         20'd256,     1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b1, 32'hFFFFFFFF,   20'd999999,  1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b1, 32'd0,          20'd0,       1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b0, 32'd0,          20'd20001,   1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b1, 32'd0,          20'd40001,   1'b1, 1'b1, 1'b0, 24'd20000},
    '{1'b1, 32'd0,          20'd60002,   1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b1, 32'd0,          20'd80003,   1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b1, 32'd0,          20'd80004,   1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b0, 32'd15,         20'd80004,   1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b1, 32'd31,         20'd999999,  1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b0, 32'd31,         20'd999999,  1'b0, 1'b0, 1'b0, 24'd0},
    '{1'b0, 32'd32,         20'd999999,  1'b0, 1'b0, 1'b0, 24'd0}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  iretf_edge_if edge_bus ();
  iretf_word_if #(.DURATION_BITS(DUR_BITS)) word_bus ();

  ir_edge_timing_filter_core #(
    .DURATION_BITS(DUR_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .edges     (edge_bus),
    .words     (word_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Filter settings and state as the block should hold them.
  logic                    pol_setting;
  logic [LIMIT_BITS-1:0]   merge_limit_us;
  logic [LIMIT_BITS-1:0]   space_limit_us;
  logic [TIMEOUT_BITS-1:0] timeout_s;
  logic [SECONDS_BITS-1:0] last_sec;
  logic [MICROS_BITS-1:0]  last_us;
  logic                    line_pol;
  logic                    space_pending;
  logic [DUR_BITS-1:0]     pending_space_us;
  logic [DUR_BITS-1:0]     pending_pulse_us;

  ir_word_t expected_words [$];
  int error_count = 0;
  bit no_idle = 1'b0;

  // Timestamp and level of the most recent edge sent.
  logic [SECONDS_BITS-1:0] cur_sec;
  logic [MICROS_BITS-1:0]  cur_us;
  logic                    cur_lvl;

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("%0t ERROR %s: got %0d, want %0d", $time, what, got, want);
  endtask

  function automatic logic [DUR_BITS-1:0] sat_sum(logic [DUR_BITS-1:0] a, logic [DUR_BITS-1:0] b);
    logic [DUR_BITS:0] s;
    s = a + b;
    return s[DUR_BITS] ? DUR_MAX : s[DUR_BITS-1:0];
  endfunction

  function automatic void filter_reset();
    pol_setting = RST_INITIAL_POLARITY;
    merge_limit_us = RST_PULSE_MERGE_LIMIT;
    space_limit_us = RST_LONG_SPACE_LIMIT;
    timeout_s = RST_TIMEOUT_SECONDS;
    last_sec = '0;
    last_us = '0;
    line_pol = RST_INITIAL_POLARITY;
    space_pending = 1'b0;
    pending_space_us = '0;
    pending_pulse_us = '0;
  endfunction

  // Works out the words caused by one edge and updates the filter state.
  function automatic void predict_edge(logic lvl, logic [SECONDS_BITS-1:0] sec,
                                       logic [MICROS_BITS-1:0] us, bit keep);
    logic [DUR_BITS-1:0] dur;
    logic [SECONDS_BITS-1:0] dsec;
    longint span;
    logic pulse;
    bit emit;
    ir_word_t out_words [$];

    if (sec < last_sec || (sec == last_sec && us < last_us)) begin
      dur = DUR_MAX;
    end else begin
      dsec = sec - last_sec;
      if (dsec > timeout_s) begin
        dur = DUR_MAX;
        if (lvl == line_pol) line_pol = ~line_pol;
      end else begin
        span = longint'(dsec) * 1000000 + longint'(us) - longint'(last_us);
        if (span < 0) dur = '0;
        else if (span > longint'(DUR_MAX)) dur = DUR_MAX;
        else dur = span[DUR_BITS-1:0];
      end
    end
    last_sec = sec;
    last_us = us;
    pulse = (lvl == line_pol);

    if (space_pending && pulse) begin
      pending_pulse_us = sat_sum(pending_pulse_us, dur);
      if (pending_pulse_us > merge_limit_us) begin
        out_words.push_back(ir_word_t'{1'b0, pending_space_us, 1'b0});
        out_words.push_back(ir_word_t'{1'b1, pending_pulse_us, 1'b0});
        space_pending = 1'b0;
        pending_pulse_us = '0;
      end
    end else begin
      emit = 1'b1;
      if (!pulse) begin
        if (!space_pending) begin
          if (dur > space_limit_us) begin
            pending_space_us = dur;
            space_pending = 1'b1;
            emit = 1'b0;
          end
        end else if (dur > space_limit_us) begin
          // Another long space: the pulses seen so far fold into the held space.
          pending_space_us = sat_sum(sat_sum(pending_space_us, pending_pulse_us), dur);
          pending_pulse_us = '0;
          emit = 1'b0;
        end else begin
          out_words.push_back(ir_word_t'{1'b0, pending_space_us, 1'b0});
          out_words.push_back(ir_word_t'{1'b1, pending_pulse_us, 1'b0});
          space_pending = 1'b0;
          pending_pulse_us = '0;
        end
      end
      if (emit) out_words.push_back(ir_word_t'{pulse, dur, 1'b0});
    end

    if (out_words.size() > 0) out_words[out_words.size()-1].last_word = 1'b1;
    if (keep) foreach (out_words[k]) expected_words.push_back(out_words[k]);
  endfunction

  function automatic int idle_length();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_INITIAL_POLARITY: begin
        pol_setting = data[0];
        line_pol = data[0];
      end
      CFG_PULSE_MERGE_LIMIT: merge_limit_us = data[LIMIT_BITS-1:0];
      CFG_LONG_SPACE_LIMIT: space_limit_us = data[LIMIT_BITS-1:0];
      CFG_TIMEOUT_SECONDS: timeout_s = data[TIMEOUT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Returns at the clock edge where the item is taken.
  task automatic send_edge(logic lvl, logic [SECONDS_BITS-1:0] sec, logic [MICROS_BITS-1:0] us);
    int gap;
    gap = no_idle ? 0 : idle_length();
    if (gap > 0) begin
      edge_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    edge_bus.valid <= 1'b1;
    edge_bus.line_level <= lvl;
    edge_bus.stamp_seconds <= sec;
    edge_bus.stamp_micros <= us;
    @(posedge clk);
    while (!edge_bus.ready) @(posedge clk);
  endtask

  task automatic drain_words(int limit);
    int waited;
    waited = 0;
    edge_bus.valid <= 1'b0;
    while (expected_words.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    // An edge that causes no word may still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic step_forward(int unsigned d);
    longint t;
    t = longint'(cur_us) + d;
    while (t >= 1000000) begin
      t -= 1000000;
      cur_sec++;
    end
    cur_us = t[MICROS_BITS-1:0];
  endtask

  // Mostly realistic edge trains, with timeouts, backward jumps and raw noise mixed in.
  task automatic random_edge();
    int unsigned pick;
    int unsigned back;
    pick = $urandom_range(99, 0);
    if (pick < 55) begin
      step_forward($urandom_range(2000, 0));
    end else if (pick < 70) begin
      step_forward($urandom_range(400, 1));
    end else if (pick < 80) begin
      step_forward($urandom_range(300000, 5000));
    end else if (pick < 85) begin
      cur_sec += $urandom_range(20, 1);
      cur_us = $urandom_range(999999, 0);
    end else if (pick < 90) begin
      cur_sec = $urandom();
      cur_us = $urandom_range(999999, 0);
    end else if (pick < 95) begin
      back = $urandom_range(50000, 1);
      if (cur_us >= back) begin
        cur_us -= back;
      end else if (cur_sec != 0) begin
        cur_sec--;
        cur_us = MICROS_BITS'(int'(cur_us) + 1000000 - int'(back));
      end else begin
        cur_sec = $urandom();
      end
    end else begin
      cur_sec += $urandom_range(1, 0);
      cur_us = $urandom_range(20'hFFFFF, 0);
    end
    if ($urandom_range(99, 0) < 85) cur_lvl = ~cur_lvl;
  endtask

  task automatic run_phase(logic pol, logic [CFG_DATA_BITS-1:0] merge,
                           logic [CFG_DATA_BITS-1:0] space, logic [CFG_DATA_BITS-1:0] tmo,
                           bit calm, int count);
    drain_words(DRAIN_LIMIT);
    no_idle = calm;
    set_reg(CFG_INITIAL_POLARITY, CFG_DATA_BITS'(pol));
    set_reg(CFG_PULSE_MERGE_LIMIT, merge);
    set_reg(CFG_LONG_SPACE_LIMIT, space);
    set_reg(CFG_TIMEOUT_SECONDS, tmo);
    set_reg(CFG_NO_SUCH_REG, '1);
    repeat (count) begin
      random_edge();
      send_edge(cur_lvl, cur_sec, cur_us);
      predict_edge(cur_lvl, cur_sec, cur_us, 1'b1);
    end
  endtask

  always @(posedge clk) begin : check_words
    ir_word_t want;
    if (!rst && word_bus.valid && word_bus.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with no edge behind it", word_bus.duration_us, 0);
      end else begin
        want = expected_words.pop_front();
        if (word_bus.is_pulse !== want.is_pulse)
          report_mismatch("is_pulse", word_bus.is_pulse, want.is_pulse);
        if (word_bus.duration_us !== want.duration_us)
          report_mismatch("duration_us", word_bus.duration_us, want.duration_us);
        if (word_bus.last_word !== want.last_word)
          report_mismatch("last_word", word_bus.last_word, want.last_word);
      end
    end
  end

  initial begin : word_ready_driver
    int burst;
    int stall;
    forever begin
      burst = $urandom_range(12, 1);
      stall = no_idle ? 0 : idle_length();
      word_bus.ready <= 1'b1;
      repeat (burst) @(posedge clk);
      if (stall > 0) begin
        word_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    edge_row_t row;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    edge_bus.valid <= 1'b0;
    edge_bus.line_level <= 1'b0;
    edge_bus.stamp_seconds <= '0;
    edge_bus.stamp_micros <= '0;
    filter_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: hold, merge, saturation, timeout flip and clock edge cases.
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      send_edge(row.lvl, row.sec, row.us);
      predict_edge(row.lvl, row.sec, row.us, !row.typed);
      if (row.typed && row.typed_has_word)
        expected_words.push_back(ir_word_t'{row.typed_pulse, row.typed_dur, 1'b1});
      cur_sec = row.sec;
      cur_us = row.us;
      cur_lvl = row.lvl;
    end

    run_phase(1'b0, 24'd3000, 24'd5000, 24'd2, 1'b0, 50);
    run_phase(1'b1, 24'd0, 24'd0, 24'd0, 1'b1, 50);
    // Upper data bits set on the timeout write; only the low five count.
    run_phase(1'b0, 24'hFFFFFF, 24'd1000, 24'hFFFFF0, 1'b0, 50);
    run_phase(1'b1, 24'd250, 24'd20000, 24'd15, 1'b0, 50);
    run_phase(1'b1, 24'd800, 24'hFFFFFF, 24'd5, 1'b0, 50);

    drain_words(DRAIN_LIMIT);
    if (expected_words.size() != 0)
      report_mismatch("words never received", 0, expected_words.size());
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
